### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define OSC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define OSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/osc_pkg.sv
package osc_pkg;

  // Field widths
  localparam int DENSITY_W   = 16;
  localparam int VOLUME_W    = 32;
  localparam int COUNT_W     = 27;
  localparam int VSUM_W      = 58;
  localparam int LAYER_OUT_W = 10;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_REG_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_U    = 2'd0,
    CFG_SIZE_V    = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_e;

  // Register reset values
  localparam logic [SIZE_REG_W-1:0] SIZE_U_RST    = 9'd256;
  localparam logic [SIZE_REG_W-1:0] SIZE_V_RST    = 9'd1;
  localparam logic [DENSITY_W-1:0]  THRESHOLD_RST = 16'd32768;

endpackage

### hw/rtl/osc_ram.sv
module osc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wmask_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b_i,
  output logic [WIDTH-1:0]                 rdata_a_o,
  output logic [WIDTH-1:0]                 rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write the masked bits of one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i[i];
        end
      end
    end
  end

  // Registered reads, held while no read is requested
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/overhang_support_check.sv
// Overhang support check over a streamed voxel grid.
// A cell passes through the stage 1 register; its result is then held in the output register.
// Throughput: one cell per cycle while the output is not stalled; each cell reads three rows of the previous plane
// from two row-wide memories split by row parity, two read ports each.
// Reset: position, bank, totals and flags clear asynchronously; the plane memories
// are not cleared, every entry is written in a layer before the next layer reads it.
`include "assert_macros.svh"

module overhang_support_check #(
  parameter int MAX_U      = 256,
  parameter int MAX_V      = 256,
  parameter int MAX_LAYERS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [osc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [osc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // cell input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [osc_pkg::DENSITY_W-1:0]       density_i,
  input  logic [osc_pkg::VOLUME_W-1:0]        element_volume_i,
  input  logic                                last_cell_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                is_solid_o,
  output logic                                is_unsupported_o,
  output logic [osc_pkg::COUNT_W-1:0]         solid_total_o,
  output logic [osc_pkg::VSUM_W-1:0]          solid_volume_sum_o,
  output logic [osc_pkg::COUNT_W-1:0]         unsupported_total_o,
  output logic [osc_pkg::VSUM_W-1:0]          unsupported_volume_sum_o,
  output logic                                has_unsupported_o,
  output logic [osc_pkg::LAYER_OUT_W-1:0]     lowest_unsupported_layer_o,
  output logic                                report_done_o
);

  localparam int U_W        = (MAX_U > 1) ? $clog2(MAX_U) : 1;
  localparam int V_W        = (MAX_V > 1) ? $clog2(MAX_V) : 1;
  localparam int L_W        = $clog2(MAX_LAYERS);
  localparam int SU_W       = $clog2(MAX_U + 1);
  localparam int SV_W       = $clog2(MAX_V + 1);
  localparam int HALF_ROWS  = (MAX_V + 1) / 2;
  localparam int HR_W       = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int RAM_AW     = HR_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;
  localparam int VSUM_EXT_W = osc_pkg::VSUM_W + 1;

  // Stage 1 holds one cell while its plane rows come back from memory
  typedef struct packed {
    logic                               solid;
    logic                               last;
    logic                               chk;
    logic                               nb_l;
    logic                               nb_r;
    logic                               nb_d;
    logic                               nb_u;
    logic                               bank;
    logic [U_W-1:0]                     u;
    logic [V_W-1:0]                     v;
    logic [osc_pkg::LAYER_OUT_W-1:0]    layer;
    logic [osc_pkg::VOLUME_W-1:0]       volume;
    logic                               fwd_c;
    logic                               fwd_d;
    logic                               fwd_up;
    logic [U_W-1:0]                     fwd_u;
    logic                               fwd_bit;
  } s1_t;

  // Configuration registers
  logic [osc_pkg::SIZE_REG_W-1:0] size_u_q;
  logic [osc_pkg::SIZE_REG_W-1:0] size_v_q;
  logic [osc_pkg::DENSITY_W-1:0]  threshold_q;

  // Scan position
  logic [U_W-1:0] pos_u_q, pos_u_d;
  logic [V_W-1:0] pos_v_q, pos_v_d;
  logic [L_W-1:0] layer_q, layer_d;
  logic           bank_q, bank_d;

  // Pipeline control
  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic out_valid_q;
  logic in_fire;
  logic s1_adv;
  logic wr_fire;

  // Result registers, which double as the running totals
  logic                            is_solid_q, is_unsup_q;
  logic [osc_pkg::COUNT_W-1:0]     solid_total_q, solid_total_d;
  logic [osc_pkg::VSUM_W-1:0]      solid_vol_q, solid_vol_d;
  logic [osc_pkg::COUNT_W-1:0]     unsup_total_q, unsup_total_d;
  logic [osc_pkg::VSUM_W-1:0]      unsup_vol_q, unsup_vol_d;
  logic                            found_q, found_d;
  logic [osc_pkg::LAYER_OUT_W-1:0] lowest_q, lowest_d;
  logic                            report_done_q;

  // Stage 0 helpers
  logic [SU_W-1:0] size_u;
  logic [SV_W-1:0] size_v;
  logic            u_more, v_more;
  logic            prev_bank;
  logic [V_W-1:0]  row_dn0, row_up0;
  logic [HR_W-1:0] half_c, half_dn, half_up;
  logic [RAM_AW-1:0] raddr_c, raddr_dn, raddr_up;

  // Memory ports
  logic [RAM_AW-1:0] waddr;
  logic [MAX_U-1:0]  wmask, wdata;
  logic              we_even, we_odd;
  logic [RAM_AW-1:0] even_raddr_a, odd_raddr_a;
  logic [MAX_U-1:0]  even_rdata_a, even_rdata_b, odd_rdata_a, odd_rdata_b;

  // Stage 1 helpers
  logic [MAX_U-1:0]  row_c, row_dn, row_up;
  logic [U_W-1:0]    u_m1, u_p1;
  logic              bit_c, bit_l, bit_r, bit_d, bit_u;
  logic              supported, unsup;
  logic [osc_pkg::COUNT_W-1:0]     cnt_s_base, cnt_u_base;
  logic [osc_pkg::VSUM_W-1:0]      vol_s_base, vol_u_base;
  logic                            found_base;
  logic [osc_pkg::LAYER_OUT_W-1:0] lowest_base;
  logic [VSUM_EXT_W-1:0]           vol_s_sum, vol_u_sum;

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_u_q    <= osc_pkg::SIZE_U_RST;
      size_v_q    <= osc_pkg::SIZE_V_RST;
      threshold_q <= osc_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (osc_pkg::cfg_idx_e'(cfg_idx_i))
        osc_pkg::CFG_SIZE_U:    size_u_q    <= cfg_wdata_i[osc_pkg::SIZE_REG_W-1:0];
        osc_pkg::CFG_SIZE_V:    size_v_q    <= cfg_wdata_i[osc_pkg::SIZE_REG_W-1:0];
        osc_pkg::CFG_THRESHOLD: threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp lateral sizes into 1..MAX
  always_comb begin
    if (size_u_q == '0) begin
      size_u = SU_W'(1);
    end else if (32'(size_u_q) > MAX_U) begin
      size_u = SU_W'(MAX_U);
    end else begin
      size_u = SU_W'(size_u_q);
    end
    if (size_v_q == '0) begin
      size_v = SV_W'(1);
    end else if (32'(size_v_q) > MAX_V) begin
      size_v = SV_W'(MAX_V);
    end else begin
      size_v = SV_W'(size_v_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign wr_fire    = s1_valid_q && s1_adv;

  // ---------------------------------------------------------------------------
  // Stage 0: neighbor ranges, read addresses, position advance
  assign u_more    = (32'(pos_u_q) + 1) < 32'(size_u);
  assign v_more    = (32'(pos_v_q) + 1) < 32'(size_v);
  assign prev_bank = ~bank_q;
  assign row_dn0   = V_W'(pos_v_q - 1'b1);
  assign row_up0   = V_W'(pos_v_q + 1'b1);
  assign half_c    = HR_W'(pos_v_q >> 1);
  assign half_dn   = HR_W'(row_dn0 >> 1);
  assign half_up   = HR_W'(row_up0 >> 1);
  assign raddr_c   = {prev_bank, half_c};
  assign raddr_dn  = {prev_bank, half_dn};
  assign raddr_up  = {prev_bank, half_up};

  // Even rows live in one memory, odd rows in the other
  assign even_raddr_a = pos_v_q[0] ? raddr_dn : raddr_c;
  assign odd_raddr_a  = pos_v_q[0] ? raddr_c  : raddr_dn;

  always_comb begin
    s1_d        = s1_q;
    s1_d.solid  = density_i >= threshold_q;
    s1_d.last   = last_cell_i;
    s1_d.chk    = layer_q != '0;
    s1_d.nb_l   = (pos_u_q != '0) && ((32'(pos_u_q) - 1) < 32'(size_u));
    s1_d.nb_r   = u_more;
    s1_d.nb_d   = (pos_v_q != '0) && ((32'(pos_v_q) - 1) < 32'(size_v));
    s1_d.nb_u   = v_more;
    s1_d.bank   = bank_q;
    s1_d.u      = pos_u_q;
    s1_d.v      = pos_v_q;
    s1_d.layer  = osc_pkg::LAYER_OUT_W'(layer_q);
    s1_d.volume = element_volume_i;
    // Forward the bit written at the same edge as this read
    s1_d.fwd_c   = wr_fire && (s1_q.bank == prev_bank) && (s1_q.v == pos_v_q);
    s1_d.fwd_d   = wr_fire && (s1_q.bank == prev_bank) && (s1_q.v == row_dn0);
    s1_d.fwd_up  = wr_fire && (s1_q.bank == prev_bank) && (s1_q.v == row_up0);
    s1_d.fwd_u   = s1_q.u;
    s1_d.fwd_bit = s1_q.solid;
  end

  // Advance raster position; wrap rows and layers, swap planes, hold the layer at its ceiling, restart on a last cell
  always_comb begin
    pos_u_d = pos_u_q;
    pos_v_d = pos_v_q;
    layer_d = layer_q;
    bank_d  = bank_q;
    if (last_cell_i) begin
      pos_u_d = '0;
      pos_v_d = '0;
      layer_d = '0;
      bank_d  = 1'b0;
    end else if (u_more) begin
      pos_u_d = U_W'(pos_u_q + 1'b1);
    end else begin
      pos_u_d = '0;
      if (v_more) begin
        pos_v_d = V_W'(pos_v_q + 1'b1);
      end else begin
        pos_v_d = '0;
        bank_d  = ~bank_q;
        if (32'(layer_q) < MAX_LAYERS - 1) begin
          layer_d = L_W'(layer_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_u_q <= '0;
      pos_v_q <= '0;
      layer_q <= '0;
      bank_q  <= 1'b0;
    end else if (in_fire) begin
      pos_u_q <= pos_u_d;
      pos_v_q <= pos_v_d;
      layer_q <= layer_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Plane memories: word = one row of MAX_U solid bits, address = {bank, row/2}
  assign waddr   = {s1_q.bank, HR_W'(s1_q.v >> 1)};
  assign wmask   = MAX_U'(1) << s1_q.u;
  assign wdata   = {MAX_U{s1_q.solid}};
  assign we_even = wr_fire && !s1_q.v[0];
  assign we_odd  = wr_fire && s1_q.v[0];

  osc_ram #(
    .WIDTH (MAX_U),
    .DEPTH (RAM_DEPTH)
  ) u_ram_even (
    .clk_i     (clk_i),
    .we_i      (we_even),
    .waddr_i   (waddr),
    .wmask_i   (wmask),
    .wdata_i   (wdata),
    .re_i      (in_fire),
    .raddr_a_i (even_raddr_a),
    .raddr_b_i (raddr_up),
    .rdata_a_o (even_rdata_a),
    .rdata_b_o (even_rdata_b)
  );

  osc_ram #(
    .WIDTH (MAX_U),
    .DEPTH (RAM_DEPTH)
  ) u_ram_odd (
    .clk_i     (clk_i),
    .we_i      (we_odd),
    .waddr_i   (waddr),
    .wmask_i   (wmask),
    .wdata_i   (wdata),
    .re_i      (in_fire),
    .raddr_a_i (odd_raddr_a),
    .raddr_b_i (raddr_up),
    .rdata_a_o (odd_rdata_a),
    .rdata_b_o (odd_rdata_b)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: support lookup with forwarding
  assign row_c  = s1_q.v[0] ? odd_rdata_a  : even_rdata_a;
  assign row_dn = s1_q.v[0] ? even_rdata_a : odd_rdata_a;
  assign row_up = s1_q.v[0] ? even_rdata_b : odd_rdata_b;
  assign u_m1   = U_W'(s1_q.u - 1'b1);
  assign u_p1   = U_W'(s1_q.u + 1'b1);

  always_comb begin
    bit_c = row_c[s1_q.u];
    bit_l = row_c[u_m1];
    bit_r = row_c[u_p1];
    bit_d = row_dn[s1_q.u];
    bit_u = row_up[s1_q.u];
    if (s1_q.fwd_c && (s1_q.fwd_u == s1_q.u)) begin
      bit_c = s1_q.fwd_bit;
    end
    if (s1_q.fwd_c && (s1_q.fwd_u == u_m1)) begin
      bit_l = s1_q.fwd_bit;
    end
    if (s1_q.fwd_c && (s1_q.fwd_u == u_p1)) begin
      bit_r = s1_q.fwd_bit;
    end
    if (s1_q.fwd_d && (s1_q.fwd_u == s1_q.u)) begin
      bit_d = s1_q.fwd_bit;
    end
    if (s1_q.fwd_up && (s1_q.fwd_u == s1_q.u)) begin
      bit_u = s1_q.fwd_bit;
    end
  end

  assign supported = bit_c || (s1_q.nb_l && bit_l) || (s1_q.nb_r && bit_r)
                     || (s1_q.nb_d && bit_d) || (s1_q.nb_u && bit_u);
  assign unsup     = s1_q.solid && s1_q.chk && !supported;

  // Totals restart from zero after the result of a last cell
  assign cnt_s_base  = report_done_q ? '0 : solid_total_q;
  assign cnt_u_base  = report_done_q ? '0 : unsup_total_q;
  assign vol_s_base  = report_done_q ? '0 : solid_vol_q;
  assign vol_u_base  = report_done_q ? '0 : unsup_vol_q;
  assign found_base  = report_done_q ? 1'b0 : found_q;
  assign lowest_base = report_done_q ? '0 : lowest_q;

  assign vol_s_sum = {1'b0, vol_s_base} + VSUM_EXT_W'(s1_q.volume);
  assign vol_u_sum = {1'b0, vol_u_base} + VSUM_EXT_W'(s1_q.volume);

  // Saturating accumulate
  always_comb begin
    solid_total_d = cnt_s_base;
    solid_vol_d   = vol_s_base;
    unsup_total_d = cnt_u_base;
    unsup_vol_d   = vol_u_base;
    found_d       = found_base;
    lowest_d      = lowest_base;
    if (s1_q.solid) begin
      solid_total_d = (cnt_s_base == '1) ? cnt_s_base : cnt_s_base + 1'b1;
      solid_vol_d   = vol_s_sum[osc_pkg::VSUM_W] ? '1 : vol_s_sum[osc_pkg::VSUM_W-1:0];
    end
    if (unsup) begin
      unsup_total_d = (cnt_u_base == '1) ? cnt_u_base : cnt_u_base + 1'b1;
      unsup_vol_d   = vol_u_sum[osc_pkg::VSUM_W] ? '1 : vol_u_sum[osc_pkg::VSUM_W-1:0];
      found_d       = 1'b1;
      // Layers never decrease within a grid, so the first hit is the lowest
      if (!found_base) begin
        lowest_d = s1_q.layer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      solid_total_q <= '0;
      solid_vol_q   <= '0;
      unsup_total_q <= '0;
      unsup_vol_q   <= '0;
      found_q       <= 1'b0;
      lowest_q      <= '0;
      report_done_q <= 1'b0;
    end else begin
      if (wr_fire) begin
        out_valid_q   <= 1'b1;
        solid_total_q <= solid_total_d;
        solid_vol_q   <= solid_vol_d;
        unsup_total_q <= unsup_total_d;
        unsup_vol_q   <= unsup_vol_d;
        found_q       <= found_d;
        lowest_q      <= lowest_d;
        report_done_q <= s1_q.last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      is_solid_q <= s1_q.solid;
      is_unsup_q <= unsup;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign is_solid_o                 = is_solid_q;
  assign is_unsupported_o           = is_unsup_q;
  assign solid_total_o              = solid_total_q;
  assign solid_volume_sum_o         = solid_vol_q;
  assign unsupported_total_o        = unsup_total_q;
  assign unsupported_volume_sum_o   = unsup_vol_q;
  assign has_unsupported_o          = found_q;
  assign lowest_unsupported_layer_o = lowest_q;
  assign report_done_o              = report_done_q;

  // ---------------------------------------------------------------------------
  // Checks
  `OSC_ASSERT_IMP(a_unsup_flagged, out_valid_q && is_unsup_q, is_solid_q && found_q, "unsupported result without solid cell or flag")
  `OSC_ASSERT_NXT(a_totals_grow, wr_fire && !report_done_q, (solid_total_q >= $past(solid_total_q)) && (unsup_total_q >= $past(unsup_total_q)) && (solid_vol_q >= $past(solid_vol_q)), "running totals decreased within a grid")
  `OSC_ASSERT_NXT(a_last_restarts, in_fire && last_cell_i, (pos_u_q == '0) && (pos_v_q == '0) && (layer_q == '0) && !bank_q, "scan position not restarted after last cell")

endmodule

### sim/tb_overhang_support_check.sv
module tb_overhang_support_check;
  import osc_pkg::*;

  localparam int MAX_U      = 256;
  localparam int MAX_V      = 256;
  localparam int MAX_LAYERS = 1024;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam longint unsigned VSUM_MAX  = (64'd1 << VSUM_W) - 64'd1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic                   is_solid;
    logic                   is_unsupported;
    logic [COUNT_W-1:0]     solid_total;
    logic [VSUM_W-1:0]      solid_volume_sum;
    logic [COUNT_W-1:0]     unsupported_total;
    logic [VSUM_W-1:0]      unsupported_volume_sum;
    logic                   has_unsupported;
    logic [LAYER_OUT_W-1:0] lowest_layer;
    logic                   report_done;
  } cell_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [DENSITY_W-1:0]   density_i;
  logic [VOLUME_W-1:0]    element_volume_i;
  logic                   last_cell_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   is_solid_o;
  logic                   is_unsupported_o;
  logic [COUNT_W-1:0]     solid_total_o;
  logic [VSUM_W-1:0]      solid_volume_sum_o;
  logic [COUNT_W-1:0]     unsupported_total_o;
  logic [VSUM_W-1:0]      unsupported_volume_sum_o;
  logic                   has_unsupported_o;
  logic [LAYER_OUT_W-1:0] lowest_unsupported_layer_o;
  logic                   report_done_o;

  // Mirror of the configuration registers
  logic [SIZE_REG_W-1:0] size_u_q = SIZE_U_RST;
  logic [SIZE_REG_W-1:0] size_v_q = SIZE_V_RST;
  logic [DENSITY_W-1:0]  thr_q    = THRESHOLD_RST;

  // Mirror of the block state: solid planes, raster position, running totals
  bit              solid_plane [2][MAX_U*MAX_V];
  bit              bank_q      = 1'b0;
  int              pos_u_q     = 0;
  int              pos_v_q     = 0;
  int              layer_q     = 0;
  longint unsigned solid_cnt_q = 0;
  longint unsigned solid_vol_q = 0;
  longint unsigned unsup_cnt_q = 0;
  longint unsigned unsup_vol_q = 0;
  bit              found_q     = 1'b0;
  int              lowest_q    = 0;

  cell_report_t pending_reports[$];
  int error_count   = 0;
  int reports_seen  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  overhang_support_check #(
    .MAX_U      (MAX_U),
    .MAX_V      (MAX_V),
    .MAX_LAYERS (MAX_LAYERS)
  ) dut (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cfg_we_i                   (cfg_we_i),
    .cfg_idx_i                  (cfg_idx_i),
    .cfg_wdata_i                (cfg_wdata_i),
    .in_valid_i                 (in_valid_i),
    .in_stall_o                 (in_stall_o),
    .density_i                  (density_i),
    .element_volume_i           (element_volume_i),
    .last_cell_i                (last_cell_i),
    .out_valid_o                (out_valid_o),
    .out_stall_i                (out_stall_i),
    .is_solid_o                 (is_solid_o),
    .is_unsupported_o           (is_unsupported_o),
    .solid_total_o              (solid_total_o),
    .solid_volume_sum_o         (solid_volume_sum_o),
    .unsupported_total_o        (unsupported_total_o),
    .unsupported_volume_sum_o   (unsupported_volume_sum_o),
    .has_unsupported_o          (has_unsupported_o),
    .lowest_unsupported_layer_o (lowest_unsupported_layer_o),
    .report_done_o              (report_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned top);
    return (a + b > top) ? top : a + b;
  endfunction

  // Compute the report of one cell and advance the mirrored state
  function automatic cell_report_t predict_report(logic [DENSITY_W-1:0] dens,
                                                  logic [VOLUME_W-1:0] vol, logic last);
    cell_report_t r;
    int  su, sv, u, v, prv, row;
    bit  solid, sup, unsup;
    su    = (size_u_q == 0) ? 1 : ((size_u_q > MAX_U) ? MAX_U : int'(size_u_q));
    sv    = (size_v_q == 0) ? 1 : ((size_v_q > MAX_V) ? MAX_V : int'(size_v_q));
    u     = pos_u_q;
    v     = pos_v_q;
    row   = v * MAX_U;
    prv   = bank_q ? 0 : 1;
    solid = (dens >= thr_q);
    unsup = 1'b0;
    if (solid) begin
      solid_cnt_q = sat_add(solid_cnt_q, 1, COUNT_MAX);
      solid_vol_q = sat_add(solid_vol_q, vol, VSUM_MAX);
      if (layer_q > 0) begin
        // Cell below plus its lateral neighbors that lie inside the grid
        sup = solid_plane[prv][row + u];
        if (u > 0 && u - 1 < su) sup |= solid_plane[prv][row + u - 1];
        if (u + 1 < su)          sup |= solid_plane[prv][row + u + 1];
        if (v > 0 && v - 1 < sv) sup |= solid_plane[prv][row - MAX_U + u];
        if (v + 1 < sv)          sup |= solid_plane[prv][row + MAX_U + u];
        if (!sup) begin
          unsup       = 1'b1;
          unsup_cnt_q = sat_add(unsup_cnt_q, 1, COUNT_MAX);
          unsup_vol_q = sat_add(unsup_vol_q, vol, VSUM_MAX);
          if (!found_q || layer_q < lowest_q) lowest_q = layer_q;
          found_q = 1'b1;
        end
      end
    end
    solid_plane[bank_q][row + u] = solid;

    r.is_solid               = solid;
    r.is_unsupported         = unsup;
    r.solid_total            = solid_cnt_q[COUNT_W-1:0];
    r.solid_volume_sum       = solid_vol_q[VSUM_W-1:0];
    r.unsupported_total      = unsup_cnt_q[COUNT_W-1:0];
    r.unsupported_volume_sum = unsup_vol_q[VSUM_W-1:0];
    r.has_unsupported        = found_q;
    r.lowest_layer           = found_q ? lowest_q[LAYER_OUT_W-1:0] : '0;
    r.report_done            = last;

    // Advance the raster position, or clear the run after the last cell
    if (last) begin
      bank_q      = 1'b0;
      pos_u_q     = 0;
      pos_v_q     = 0;
      layer_q     = 0;
      solid_cnt_q = 0;
      solid_vol_q = 0;
      unsup_cnt_q = 0;
      unsup_vol_q = 0;
      found_q     = 1'b0;
      lowest_q    = 0;
    end else if (u + 1 < su) begin
      pos_u_q = u + 1;
    end else begin
      pos_u_q = 0;
      if (v + 1 < sv) begin
        pos_v_q = v + 1;
      end else begin
        pos_v_q = 0;
        if (layer_q < MAX_LAYERS - 1) layer_q++;
        bank_q = ~bank_q;
      end
    end
    return r;
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR result %0d: %s", reports_seen, msg);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0h, got %0h", name, want, got));
  endfunction

  // Compare one accepted result with the oldest pending report
  task automatic check_report();
    cell_report_t want;
    if (pending_reports.size() == 0) begin
      flag_error("result transfer with no pending report");
    end else begin
      want = pending_reports.pop_front();
      compare_field("is_solid", want.is_solid, is_solid_o);
      compare_field("is_unsupported", want.is_unsupported, is_unsupported_o);
      compare_field("solid_total", want.solid_total, solid_total_o);
      compare_field("solid_volume_sum", want.solid_volume_sum, solid_volume_sum_o);
      compare_field("unsupported_total", want.unsupported_total, unsupported_total_o);
      compare_field("unsupported_volume_sum", want.unsupported_volume_sum,
                    unsupported_volume_sum_o);
      compare_field("has_unsupported", want.has_unsupported, has_unsupported_o);
      compare_field("lowest_unsupported_layer", want.lowest_layer,
                    lowest_unsupported_layer_o);
      compare_field("report_done", want.report_done, report_done_o);
    end
    reports_seen++;
  endtask

  // Sample result transfers, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_report();
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Present one cell, hold it until the transfer, record its report
  task automatic send_cell(logic [DENSITY_W-1:0] dens, logic [VOLUME_W-1:0] vol,
                           logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    density_i        <= dens;
    element_volume_i <= vol;
    last_cell_i      <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_reports.push_back(predict_report(dens, vol, last));
  endtask

  // Drop valid and wait for every pending report
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_grid(logic [CFG_DATA_W-1:0] u, logic [CFG_DATA_W-1:0] v,
                              logic [CFG_DATA_W-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SIZE_U;
    cfg_wdata_i <= u;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIZE_V;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_u_q = u[SIZE_REG_W-1:0];
    size_v_q = v[SIZE_REG_W-1:0];
    thr_q    = thr[DENSITY_W-1:0];
  endtask

  // Density on the requested side of the threshold, often right at it
  function automatic logic [DENSITY_W-1:0] pick_density(bit want_solid);
    if (want_solid || thr_q == 0) begin
      case ($urandom_range(0, 3))
        0:       return thr_q;
        1:       return 16'hFFFF;
        default: return $urandom_range(thr_q, 16'hFFFF);
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return thr_q - 1;
      1:       return 16'h0000;
      default: return $urandom_range(0, thr_q - 1);
    endcase
  endfunction

  function automatic logic [VOLUME_W-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Stream whole grids of random length, each closed by its last cell
  task automatic run_grids(int budget, int min_len, int max_len);
    int len, solid_pct;
    logic [DENSITY_W-1:0] dens;
    while (budget > 0) begin
      len = $urandom_range(min_len, max_len);
      if (len > budget) len = budget;
      case ($urandom_range(0, 2))
        0:       solid_pct = 25;
        1:       solid_pct = 55;
        default: solid_pct = 85;
      endcase
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) dens = $urandom;
        else dens = pick_density($urandom_range(0, 99) < solid_pct);
        send_cell(dens, pick_volume(), i == len - 1);
      end
      budget -= len;
    end
  endtask

  // Reset sizes and threshold, threshold edges, last cell inside a layer
  task automatic test_reset_defaults();
    send_cell(16'h7FFF, 32'hFFFF_FFFF, 1'b0);
    send_cell(16'h8000, 32'hFFFF_FFFF, 1'b0);
    send_cell(16'hFFFF, 32'h0000_0000, 1'b0);
    send_cell(16'h0000, $urandom, 1'b1);
    drain();
  endtask

  // One solid center cell under a full layer: support straight below,
  // through each lateral neighbor, and none for the corners
  task automatic test_support_shapes();
    program_grid(16'd3, 16'd3, 16'h4000);
    for (int i = 0; i < 9; i++)
      send_cell((i == 4) ? 16'h4000 : ((i % 2) ? 16'h3FFF : 16'h0000), pick_volume(), 1'b0);
    for (int i = 0; i < 9; i++) send_cell(16'hFFFF, pick_volume(), i == 8);
    drain();
  endtask

  // Shrink the row while a layer is open: the position wraps at its next
  // advance and cells beyond the new edge no longer give support
  task automatic test_size_shrink();
    program_grid(16'd6, 16'd1, 16'h8000);
    send_cell(16'hFFFF, pick_volume(), 1'b0);
    send_cell(16'h0000, pick_volume(), 1'b0);
    send_cell(16'h0000, pick_volume(), 1'b0);
    send_cell(16'h8000, pick_volume(), 1'b0);
    send_cell(16'h0000, pick_volume(), 1'b0);
    drain();
    program_grid(16'd3, 16'd1, 16'h8000);
    send_cell(16'h7FFF, pick_volume(), 1'b0);
    for (int i = 0; i < 3; i++) send_cell(16'hFFFF, pick_volume(), i == 2);
    drain();
  endtask

  task automatic test_random_grids();
    program_grid(16'd4, 16'd3, $urandom_range(1, 16'hFFFE));
    run_grids(200, 12, 60);
    drain();
    send_idle_pct = 61;
    recv_idle_pct = 38;
    // Oversized row clamps to the plane width, zero rows act as one
    program_grid(16'd511, 16'd0, 16'hFFFF);
    run_grids(300, 300, 300);
    drain();
    program_grid(16'd0, 16'd1, 16'h0000);
    run_grids(40, 5, 20);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_grid(16'd6, 16'd5, 16'h8000);
    run_grids(150, 30, 100);
    drain();
  endtask

  // Single-cell layers past the layer ceiling; first overhang lands there
  task automatic test_layer_ceiling();
    program_grid(16'd1, 16'd1, 16'h8000);
    for (int i = 0; i < MAX_LAYERS + 6; i++)
      send_cell(pick_density(!(i == MAX_LAYERS - 1 || i == MAX_LAYERS + 2)), pick_volume(),
                i == MAX_LAYERS + 5);
    drain();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_SIZE_U;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    density_i        <= '0;
    element_volume_i <= '0;
    last_cell_i      <= 1'b0;
    out_stall_i      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 61;
    test_reset_defaults();
    test_support_shapes();
    test_size_shrink();
    test_random_grids();
    test_layer_ceiling();

    // Let any stray result show up
    repeat (4) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
